>>> hdl/ole_pkg.sv
package ole_pkg;

  // command codes
  typedef enum logic [3:0] {
    OP_INS_FIRST = 4'd0,
    OP_INS_LAST  = 4'd1,
    OP_INS_POS   = 4'd2,
    OP_INS_AFTER = 4'd3,
    OP_DEL_FIRST = 4'd4,
    OP_DEL_LAST  = 4'd5,
    OP_DEL_POS   = 4'd6,
    OP_DEL_VALUE = 4'd7,
    OP_SEARCH    = 4'd8
  } opcode_t;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_BAD_POS   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  localparam int IN_BITS  = 80;
  localparam int OUT_BITS = 80;

  // one result beat
  typedef struct packed {
    logic              second_last_valid;
    logic signed [31:0] second_last_value;
    logic              last_valid;
    logic signed [31:0] last_value;
    logic [4:0]        entry_count;
    logic [4:0]        found_position;
    logic [2:0]        status;
  } result_t;

endpackage

>>> hdl/ole_mem.sv
module ole_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] mem [DEPTH];

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/ole_ctrl.sv
module ole_ctrl import ole_pkg::*; #(
  parameter int LIST_DEPTH = 16,
  parameter int AW         = 4,
  parameter int CW         = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  logic [3:0]    cmd_opcode,
  input  logic [31:0]   cmd_value,
  input  logic [31:0]   cmd_anchor,
  input  logic [7:0]    cmd_position,
  output logic          res_load,
  input  logic          res_free,
  output result_t       res,
  output logic          mem_we,
  output logic [AW-1:0] mem_wa,
  output logic [31:0]   mem_wd,
  output logic          mem_re,
  output logic [AW-1:0] mem_ra,
  input  logic [31:0]   mem_rd
);

  localparam int PW = ((CW > 8) ? CW : 8) + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_SC_RD, S_SC_CHK, S_MV_RD, S_MV_WR, S_COMMIT,
    S_T_RD1, S_T_RD2, S_T_CAP, S_FIN
  } state_t;

  state_t       state;
  logic [3:0]   op;
  logic [31:0]  val;
  logic [31:0]  key;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] i;
  logic         ins;
  logic [2:0]   status;
  logic [CW-1:0] found;
  logic [31:0]  last;
  logic [31:0]  second;

  logic [PW-1:0] posx;
  logic [PW-1:0] cntx;
  logic [CW-1:0] i_dec;
  logic [CW-1:0] i_inc;
  logic [CW-1:0] cnt_dec;
  logic [CW-1:0] cnt_dec2;
  logic          full;
  logic          empty;

  assign posx     = PW'(cmd_position);
  assign cntx     = PW'(count);
  assign i_dec    = i - 1'b1;
  assign i_inc    = i + 1'b1;
  assign cnt_dec  = count - 1'b1;
  assign cnt_dec2 = count - CW'(2);
  assign full     = (count == CW'(LIST_DEPTH));
  assign empty    = (count == '0);
  assign cmd_ready = (state == S_IDLE) && !rst;
  assign res_load  = (state == S_FIN) && res_free;

  // memory port controls
  always_comb begin
    mem_we = 1'b0;
    mem_wa = i[AW-1:0];
    mem_wd = mem_rd;
    mem_re = 1'b0;
    mem_ra = i[AW-1:0];
    case (state)
      S_SC_RD: begin
        mem_re = (i != count);
      end
      S_MV_RD: begin
        mem_re = 1'b1;
        mem_ra = ins ? i_dec[AW-1:0] : i_inc[AW-1:0];
      end
      S_MV_WR: begin
        mem_we = 1'b1;
      end
      S_COMMIT: begin
        mem_we = ins;
        mem_wa = idx[AW-1:0];
        mem_wd = val;
      end
      S_T_RD1: begin
        mem_re = 1'b1;
        mem_ra = cnt_dec[AW-1:0];
      end
      S_T_RD2: begin
        mem_re = 1'b1;
        mem_ra = cnt_dec2[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  // result fields
  always_comb begin
    res.status            = status;
    res.found_position    = 5'(found);
    res.entry_count       = 5'(count);
    res.last_valid        = (count != '0);
    res.last_value        = (count != '0) ? last : '0;
    res.second_last_valid = (count > CW'(1));
    res.second_last_value = (count > CW'(1)) ? second : '0;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            op     <= cmd_opcode;
            val    <= cmd_value;
            key    <= (cmd_opcode == OP_INS_AFTER) ? cmd_anchor : cmd_value;
            status <= ST_OK;
            found  <= '0;
            i      <= '0;
            case (cmd_opcode)
              OP_INS_FIRST, OP_INS_LAST, OP_INS_POS: begin
                if (full) begin
                  status <= ST_FULL;
                  state  <= S_T_RD1;
                end else begin
                  ins <= 1'b1;
                  i   <= count;
                  if (cmd_opcode == OP_INS_FIRST || (cmd_opcode == OP_INS_POS &&
                      posx <= PW'(1))) begin
                    idx   <= '0;
                    state <= (count != '0) ? S_MV_RD : S_COMMIT;
                  end else if (cmd_opcode == OP_INS_LAST ||
                               (posx - PW'(1)) >= cntx) begin
                    idx   <= count;
                    state <= S_COMMIT;
                  end else begin
                    idx   <= CW'(posx - PW'(1));
                    state <= S_MV_RD;
                  end
                end
              end
              OP_INS_AFTER: begin
                if (full) begin
                  status <= ST_FULL;
                  state  <= S_T_RD1;
                end else begin
                  state <= S_SC_RD;
                end
              end
              OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_POS: begin
                ins <= 1'b0;
                if (empty) begin
                  status <= ST_EMPTY;
                  state  <= S_T_RD1;
                end else if (cmd_opcode == OP_DEL_POS && posx >= cntx) begin
                  status <= ST_BAD_POS;
                  state  <= S_T_RD1;
                end else if (cmd_opcode == OP_DEL_LAST) begin
                  idx   <= cnt_dec;
                  state <= S_COMMIT;
                end else begin
                  idx   <= (cmd_opcode == OP_DEL_POS) ? CW'(posx) : '0;
                  i     <= (cmd_opcode == OP_DEL_POS) ? CW'(posx) : '0;
                  state <= (((cmd_opcode == OP_DEL_POS) ? CW'(posx) : '0) + 1'b1
                            < count) ? S_MV_RD : S_COMMIT;
                end
              end
              OP_DEL_VALUE: begin
                if (empty) begin
                  status <= ST_EMPTY;
                  state  <= S_T_RD1;
                end else begin
                  state <= S_SC_RD;
                end
              end
              OP_SEARCH: begin
                state <= S_SC_RD;
              end
              default: begin
                state <= S_T_RD1;
              end
            endcase
          end
        end
        // scan for the first match
        S_SC_RD: begin
          if (i == count) begin
            status <= ST_NOT_FOUND;
            state  <= S_T_RD1;
          end else begin
            state <= S_SC_CHK;
          end
        end
        S_SC_CHK: begin
          if (mem_rd == key) begin
            case (op)
              OP_INS_AFTER: begin
                ins   <= 1'b1;
                idx   <= i_inc;
                i     <= count;
                state <= (count > i_inc) ? S_MV_RD : S_COMMIT;
              end
              OP_DEL_VALUE: begin
                ins   <= 1'b0;
                idx   <= i;
                state <= ((i_inc) < count) ? S_MV_RD : S_COMMIT;
              end
              default: begin
                found <= i_inc;
                state <= S_T_RD1;
              end
            endcase
          end else begin
            i     <= i_inc;
            state <= S_SC_RD;
          end
        end
        // shift one cell
        S_MV_RD: begin
          state <= S_MV_WR;
        end
        S_MV_WR: begin
          if (ins) begin
            i     <= i_dec;
            state <= (i_dec > idx) ? S_MV_RD : S_COMMIT;
          end else begin
            i     <= i_inc;
            state <= ((i_inc + 1'b1) < count) ? S_MV_RD : S_COMMIT;
          end
        end
        S_COMMIT: begin
          count <= ins ? (count + 1'b1) : cnt_dec;
          state <= S_T_RD1;
        end
        // fetch the two tail cells
        S_T_RD1: begin
          state <= S_T_RD2;
        end
        S_T_RD2: begin
          last  <= mem_rd;
          state <= S_T_CAP;
        end
        S_T_CAP: begin
          second <= mem_rd;
          state  <= S_FIN;
        end
        S_FIN: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/ordered_list_engine_top.sv
// channel | dir | tdata fields (lsb first)
// s_*     | in  | opcode[3:0] value[35:4] anchor_value[67:36] position[75:68]
// m_*     | out | status[2:0] found_position[7:3] entry_count[12:8] last_value[44:13]
//         |     | last_valid[45] second_last_value[77:46] second_last_valid[78]
// a command scans the list cell by cell for a match where needed, shifts cells one at a time,
// writes the change and then reads the two tail cells; the list memory moves one cell per
// read and write
// rst clears the element count, the sequencer state and the output valid; the list memory is left as it is
// a finished result sits in the output register while the next command is taken;
// the sequencer waits at its last step only while that register is still full
module ordered_list_engine_top import ole_pkg::*; #(
  parameter int LIST_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [IN_BITS-1:0]  s_tdata,  // opcode, value, anchor_value, position
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OUT_BITS-1:0] m_tdata   // status, found_position, entry_count,
                                        // last_value, last_valid,
                                        // second_last_value, second_last_valid
);

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);

  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [31:0]   mem_wd;
  logic          mem_re;
  logic [AW-1:0] mem_ra;
  logic [31:0]   mem_rd;
  logic          res_load;
  logic          res_free;
  result_t       res;
  result_t       out_reg;

  ole_mem #(.DEPTH(LIST_DEPTH), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_en   (mem_re),
    .rd_addr (mem_ra),
    .rd_data (mem_rd)
  );

  ole_ctrl #(.LIST_DEPTH(LIST_DEPTH), .AW(AW), .CW(CW)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (s_tvalid),
    .cmd_ready    (s_tready),
    .cmd_opcode   (s_tdata[3:0]),
    .cmd_value    (s_tdata[35:4]),
    .cmd_anchor   (s_tdata[67:36]),
    .cmd_position (s_tdata[75:68]),
    .res_load     (res_load),
    .res_free     (res_free),
    .res          (res),
    .mem_we       (mem_we),
    .mem_wa       (mem_wa),
    .mem_wd       (mem_wd),
    .mem_re       (mem_re),
    .mem_ra       (mem_ra),
    .mem_rd       (mem_rd)
  );

  assign res_free = !m_tvalid || m_tready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_reg <= res;
    end
  end

  assign m_tdata = OUT_BITS'(out_reg);

endmodule

>>> hdl/ole_checker.sv
module ole_checker import ole_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OUT_BITS-1:0] m_tdata
);

  // a stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // two elements imply one
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[78] |-> m_tdata[45])
    else $error("second-last valid without last valid");

  // a found position comes only with ok status
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[7:3] != 5'd0) |-> m_tdata[2:0] == ST_OK)
    else $error("found position with bad status");

  // empty list shows zero tail value
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[45] |-> m_tdata[44:13] == 32'd0)
    else $error("tail value set on empty list");

endmodule

bind ordered_list_engine_top ole_checker u_ole_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ole_pkg::*;

  localparam int DEPTH = 16;

  typedef struct {
    logic [2:0]         status;
    logic [4:0]         found_position;
    logic [4:0]         entry_count;
    logic signed [31:0] last_value;
    logic               last_valid;
    logic signed [31:0] second_last_value;
    logic               second_last_valid;
  } list_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [IN_BITS-1:0]  s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_BITS-1:0] m_tdata;

  // shadow copy of the list
  logic signed [31:0] shadow_list[DEPTH];
  int                 shadow_count;
  list_result_t       pending_results[$];
  int                 error_count = 0;
  int                 result_count = 0;
  int                 sent_count = 0;
  int                 hold_off_cycles = 0;
  bit                 random_ready = 1'b0;

  ordered_list_engine_top #(.LIST_DEPTH(DEPTH)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #4 clk = ~clk;

  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int find_value(logic signed [31:0] v);
    int i;
    for (i = 0; i < shadow_count; i++) if (shadow_list[i] == v) return i;
    return shadow_count;
  endfunction

  function automatic void list_put(int idx, logic signed [31:0] v);
    for (int i = shadow_count; i > idx; i--) shadow_list[i] = shadow_list[i-1];
    shadow_list[idx] = v;
    shadow_count++;
  endfunction

  function automatic void list_take(int idx);
    for (int i = idx; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
    shadow_count--;
  endfunction

  // apply one command to the shadow list and queue the expected result
  function automatic void predict_list_command(logic [3:0] op, logic signed [31:0] val,
                                               logic signed [31:0] anc, logic [7:0] pos);
    list_result_t r;
    int idx;
    bit full;
    bit empty;
    full = shadow_count >= DEPTH;
    empty = shadow_count == 0;
    r.status = ST_OK;
    r.found_position = '0;
    case (op)
      OP_INS_FIRST: if (full) r.status = ST_FULL; else list_put(0, val);
      OP_INS_LAST:  if (full) r.status = ST_FULL; else list_put(shadow_count, val);
      OP_INS_POS: begin
        if (full) r.status = ST_FULL;
        else begin
          idx = (pos <= 1) ? 0 : int'(pos) - 1;
          if (idx > shadow_count) idx = shadow_count;
          list_put(idx, val);
        end
      end
      OP_INS_AFTER: begin
        if (full) r.status = ST_FULL;
        else begin
          idx = find_value(anc);
          if (idx >= shadow_count) r.status = ST_NOT_FOUND;
          else list_put(idx + 1, val);
        end
      end
      OP_DEL_FIRST: if (empty) r.status = ST_EMPTY; else list_take(0);
      OP_DEL_LAST:  if (empty) r.status = ST_EMPTY; else list_take(shadow_count - 1);
      OP_DEL_POS: begin
        if (empty) r.status = ST_EMPTY;
        else if (int'(pos) >= shadow_count) r.status = ST_BAD_POS;
        else list_take(int'(pos));
      end
      OP_DEL_VALUE: begin
        if (empty) r.status = ST_EMPTY;
        else begin
          idx = find_value(val);
          if (idx >= shadow_count) r.status = ST_NOT_FOUND;
          else list_take(idx);
        end
      end
      OP_SEARCH: begin
        idx = find_value(val);
        if (idx >= shadow_count) r.status = ST_NOT_FOUND;
        else r.found_position = 5'(idx + 1);
      end
      default: ;
    endcase
    r.entry_count = 5'(shadow_count);
    r.last_valid = shadow_count >= 1;
    r.last_value = r.last_valid ? shadow_list[shadow_count-1] : '0;
    r.second_last_valid = shadow_count >= 2;
    r.second_last_value = r.second_last_valid ? shadow_list[shadow_count-2] : '0;
    pending_results.push_back(r);
  endfunction

  // send one command beat after a random or given gap
  task automatic send_command(logic [3:0] op, logic signed [31:0] val,
                              logic signed [31:0] anc, logic [7:0] pos, int gap = -1);
    int wait_cycles;
    wait_cycles = (gap < 0) ? $urandom_range(0, 14) : gap;
    if (wait_cycles > 0) begin
      s_tvalid <= 1'b0;
      repeat (wait_cycles) @(negedge clk);
    end
    s_tdata  <= {4'b0, pos, anc, val, op};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    predict_list_command(op, val, anc, pos);
    sent_count++;
    @(negedge clk);
  endtask

  // drop the offer and wait until every result is back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  // values mostly drawn from a small pool so that searches and anchors hit often
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 7)) - 3;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_present();
    if (shadow_count != 0 && $urandom_range(0, 3) != 0)
      return shadow_list[$urandom_range(0, shadow_count - 1)];
    return pick_value();
  endfunction

  // receiver: always ready, random stalls, or a long counted hold-off
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      m_tready <= 1'b0;
    end else if (random_ready) begin
      m_tready <= ($urandom_range(0, 14) < 9);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    list_result_t exp_r;
    result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[78:0]);
      result_count++;
      if (pending_results.size() == 0) begin
        $error("unexpected result beat");
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got.status !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, got.status); error_count++;
        end
        if (got.found_position !== exp_r.found_position) begin
          $error("found_position exp %0d got %0d", exp_r.found_position,
                 got.found_position); error_count++;
        end
        if (got.entry_count !== exp_r.entry_count) begin
          $error("entry_count exp %0d got %0d", exp_r.entry_count, got.entry_count);
          error_count++;
        end
        if (got.last_value !== exp_r.last_value) begin
          $error("last_value exp %0d got %0d", exp_r.last_value, got.last_value);
          error_count++;
        end
        if (got.last_valid !== exp_r.last_valid) begin
          $error("last_valid exp %0d got %0d", exp_r.last_valid, got.last_valid);
          error_count++;
        end
        if (got.second_last_value !== exp_r.second_last_value) begin
          $error("second_last_value exp %0d got %0d", exp_r.second_last_value,
                 got.second_last_value); error_count++;
        end
        if (got.second_last_valid !== exp_r.second_last_valid) begin
          $error("second_last_valid exp %0d got %0d", exp_r.second_last_valid,
                 got.second_last_valid); error_count++;
        end
      end
    end
  end

  // empty list, fill to full, overflow, edge positions, misses and unknown opcodes
  task automatic test_directed();
    send_command(OP_DEL_FIRST, 0, 0, 0);
    send_command(OP_DEL_LAST, 0, 0, 0);
    send_command(OP_DEL_POS, 0, 0, 0);
    send_command(OP_DEL_VALUE, 5, 0, 0);
    send_command(OP_SEARCH, 5, 0, 0);
    send_command(OP_INS_AFTER, 1, 9, 0);
    send_command(OP_INS_FIRST, 32'sh7fffffff, 0, 0);
    send_command(OP_INS_LAST, 32'sh80000000, 0, 0);
    send_command(OP_INS_POS, 7, 0, 0);
    send_command(OP_INS_POS, 8, 0, 1);
    send_command(OP_INS_POS, 9, 0, 8'hff);
    send_command(OP_INS_AFTER, -1, 32'sh7fffffff, 0);
    send_command(OP_INS_AFTER, 3, 55, 0);
    send_command(OP_SEARCH, 32'sh80000000, 0, 0);
    send_command(OP_DEL_POS, 0, 0, 8'hff);
    send_command(OP_DEL_POS, 0, 0, 2);
    send_command(OP_DEL_VALUE, -1, 0, 0);
    send_command(OP_DEL_VALUE, 1234, 0, 0);
    send_command(4'd9, 0, 0, 0);
    send_command(4'd15, -1, -1, 8'hff);
    while (shadow_count < DEPTH) send_command(OP_INS_LAST, shadow_count, 0, 0, 0);
    send_command(OP_INS_FIRST, 1, 0, 0);
    send_command(OP_INS_AFTER, 1, 99, 0);
    send_command(OP_SEARCH, 15, 0, 0);
    wait_drained();
  endtask

  // receiver held off while the sender keeps offering
  task automatic test_backpressure();
    @(negedge clk);
    hold_off_cycles = 300;
    repeat (10) send_command(OP_DEL_FIRST, 0, 0, 0, 0);
    wait_drained();
  endtask

  // random commands biased towards hits
  task automatic test_random(int count);
    logic [3:0] op;
    random_ready = 1'b1;
    for (int n = 0; n < count; n++) begin
      op = ($urandom_range(0, 40) == 0) ? 4'($urandom_range(9, 15))
                                        : 4'($urandom_range(0, 8));
      if (shadow_count >= DEPTH - 2 && op <= OP_INS_AFTER && $urandom_range(0, 1))
        op = OP_DEL_POS;
      send_command(op, (op >= OP_DEL_VALUE) ? pick_present() : pick_value(),
                   pick_present(),
                   $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 17)),
                   $urandom_range(0, 3) == 0 ? 0 : -1);
      if (n == count / 2) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    shadow_count = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random(820);
    repeat (100) @(posedge clk);
    $display("sent %0d commands, checked %0d results, including overflow, empty",
             sent_count, result_count);
    $display("list deletes and a long output stall");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/ole_pkg.sv
hdl/ole_mem.sv
hdl/ole_ctrl.sv
hdl/ordered_list_engine_top.sv
hdl/ole_checker.sv
tb/testbench.sv
